@@ hw/rtl/ctsg_pkg.sv @@
// Shared types, constants and tables for the cubic trajectory setpoint generator.
// Used by ctsg_ctrl, ctsg_dp and the top level; depends on nothing else.
`default_nettype none
package ctsg_pkg;

    localparam int unsigned AXES      = 3;
    localparam int unsigned CRD_STEPS = 16;

    localparam logic [2:0]  CFG_START_X = 3'd0;
    localparam logic [2:0]  CFG_START_Y = 3'd1;
    localparam logic [2:0]  CFG_START_Z = 3'd2;
    localparam logic [2:0]  CFG_END_X   = 3'd3;
    localparam logic [2:0]  CFG_END_Y   = 3'd4;
    localparam logic [2:0]  CFG_END_Z   = 3'd5;
    localparam logic [2:0]  CFG_DUR     = 3'd6;

    localparam logic [15:0] DUR_RESET   = 16'd20;
    localparam logic [5:0]  LAST_BIT    = 6'd32;
    localparam logic [5:0]  LAST_CRD    = 6'd15;
    localparam logic signed [19:0] PI_Q16 = 20'sd205887;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_DIV_INIT, OP_DIV_STEP, OP_MUL_INIT, OP_MUL_STEP,
        OP_MUL_STORE, OP_COR_INIT, OP_COR_STEP, OP_OUT
    } t_op;

    // multiplications in order of issue
    typedef enum logic [2:0] {
        MS_SS, MS_S3, MS_PH, MS_PG, MS_PU
    } t_sel;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DIV, S_MINIT, S_MRUN, S_MSTORE, S_CINIT, S_CRUN, S_OUT
    } t_state;

    typedef struct packed {
        t_op        op;
        t_sel       sel;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic over;
        logic last;
        logic out_free;
    } t_stat;

    // arctangent of 2^-i in Q.16
    function automatic logic [16:0] atan_q16(input logic [3:0] i);
        logic [16:0] v;
        case (i)
            4'd0:    v = 17'd51472;
            4'd1:    v = 17'd30386;
            4'd2:    v = 17'd16055;
            4'd3:    v = 17'd8150;
            4'd4:    v = 17'd4091;
            4'd5:    v = 17'd2047;
            4'd6:    v = 17'd1024;
            4'd7:    v = 17'd512;
            4'd8:    v = 17'd256;
            4'd9:    v = 17'd128;
            4'd10:   v = 17'd64;
            4'd11:   v = 17'd32;
            4'd12:   v = 17'd16;
            4'd13:   v = 17'd8;
            4'd14:   v = 17'd4;
            default: v = 17'd2;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/cubic_trajectory_setpoint_generator.sv @@
// Top level: configuration registers, sequencer and datapath.
// Depends on ctsg_pkg, ctsg_ctrl and ctsg_dp.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------------
//   input    | in        | i_valid / o_stall         | i_restart
//   result   | out       | o_valid / i_stall         | o_pos_*, o_vel_*, o_acc_*,
//            |           |                           | o_heading, o_tick_index
//   config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A tick that yields a setpoint goes through these steps in order: accept, check
// the count, the bit-serial divide, eleven passes of the shared shift-add
// multiplier, the CORDIC and loading the result. A tick past the duration
// finishes after the count check, with no result.
// Reset is synchronous and active low; it clears the tick count and loads the
// registers with their defaults. The result waits in its own register, so a
// stall there holds the following tick only in its final step, loading the result.
`default_nettype none
module cubic_trajectory_setpoint_generator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_restart,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [31:0] o_pos_x,
    output logic [31:0] o_pos_y,
    output logic [31:0] o_pos_z,
    output logic [35:0] o_vel_x,
    output logic [35:0] o_vel_y,
    output logic [35:0] o_vel_z,
    output logic [35:0] o_acc_x,
    output logic [35:0] o_acc_y,
    output logic [35:0] o_acc_z,
    output logic [18:0] o_heading,
    output logic [15:0] o_tick_index,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);
    import ctsg_pkg::*;

    logic [2:0][31:0] r_start, r_end;
    logic [15:0]      r_dur;
    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [2:0][31:0] w_pos;
    logic [2:0][35:0] w_vel, w_acc;

    assign o_cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= '0;
            r_dur   <= DUR_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_X: r_start[0] <= i_cfg_data;
                CFG_START_Y: r_start[1] <= i_cfg_data;
                CFG_START_Z: r_start[2] <= i_cfg_data;
                CFG_END_X:   r_end[0]   <= i_cfg_data;
                CFG_END_Y:   r_end[1]   <= i_cfg_data;
                CFG_END_Z:   r_end[2]   <= i_cfg_data;
                CFG_DUR:     r_dur      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    ctsg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    ctsg_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_restart    (i_restart),
        .i_start      (r_start),
        .i_end        (r_end),
        .i_dur        (r_dur),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_pos        (w_pos),
        .o_vel        (w_vel),
        .o_acc        (w_acc),
        .o_heading    (o_heading),
        .o_tick_index (o_tick_index)
    );

    // split per-axis result
    assign o_pos_x = w_pos[0];
    assign o_pos_y = w_pos[1];
    assign o_pos_z = w_pos[2];
    assign o_vel_x = w_vel[0];
    assign o_vel_y = w_vel[1];
    assign o_vel_z = w_vel[2];
    assign o_acc_x = w_acc[0];
    assign o_acc_y = w_acc[1];
    assign o_acc_z = w_acc[2];

endmodule
`default_nettype wire

@@ hw/rtl/ctsg_ctrl.sv @@
// Sequencer for the setpoint generator: divide, multiplications, CORDIC, output.
// Depends on ctsg_pkg; drives ctsg_dp through t_cmd and reads t_stat.
`default_nettype none
module ctsg_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_stall,
    input  ctsg_pkg::t_stat i_stat,
    output ctsg_pkg::t_cmd  o_cmd
);
    import ctsg_pkg::*;

    t_state     r_state, n_state;
    t_sel       r_sel, n_sel;
    logic [1:0] r_axis, n_axis;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= MS_SS;
            r_axis  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_axis  <= n_axis;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_axis  = r_axis;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_stat.over ? S_IDLE : S_DIV;
                n_sel   = MS_SS;
                n_axis  = 2'd0;
            end
            S_DIV: begin
                if (i_stat.last) n_state = S_MINIT;
            end
            S_MINIT: n_state = S_MRUN;
            S_MRUN: begin
                if (i_stat.last) n_state = S_MSTORE;
            end
            S_MSTORE: begin
                n_state = S_MINIT;
                case (r_sel)
                    MS_SS: n_sel = MS_S3;
                    MS_S3: n_sel = MS_PH;
                    MS_PH: n_sel = MS_PG;
                    MS_PG: n_sel = MS_PU;
                    default: begin
                        n_sel = MS_PH;
                        if (r_axis == 2'd2) n_state = S_CINIT;
                        else n_axis = r_axis + 2'd1;
                    end
                endcase
            end
            S_CINIT: n_state = S_CRUN;
            S_CRUN: begin
                if (i_stat.last) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.sel  = r_sel;
        o_cmd.axis = r_axis;
        o_stall    = (r_state != S_IDLE);
        case (r_state)
            S_IDLE:   if (i_valid) o_cmd.op = OP_LOAD;
            S_CHECK:  if (!i_stat.over) o_cmd.op = OP_DIV_INIT;
            S_DIV:    o_cmd.op = OP_DIV_STEP;
            S_MINIT:  o_cmd.op = OP_MUL_INIT;
            S_MRUN:   o_cmd.op = OP_MUL_STEP;
            S_MSTORE: o_cmd.op = OP_MUL_STORE;
            S_CINIT:  o_cmd.op = OP_COR_INIT;
            S_CRUN:   o_cmd.op = OP_COR_STEP;
            S_OUT:    if (i_stat.out_free) o_cmd.op = OP_OUT;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/ctsg_dp.sv @@
// Datapath: tick counter, bit-serial divider, shared shift-add multiplier,
// per-axis finish, CORDIC heading and output register. Depends on ctsg_pkg.
`default_nettype none
module ctsg_dp (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  ctsg_pkg::t_cmd        i_cmd,
    output ctsg_pkg::t_stat       o_stat,
    input  wire                   i_restart,
    input  wire  [2:0][31:0]      i_start,
    input  wire  [2:0][31:0]      i_end,
    input  wire  [15:0]           i_dur,
    input  wire                   i_stall,
    output logic                  o_valid,
    output logic [2:0][31:0]      o_pos,
    output logic [2:0][35:0]      o_vel,
    output logic [2:0][35:0]      o_acc,
    output logic [18:0]           o_heading,
    output logic [15:0]           o_tick_index
);
    import ctsg_pkg::*;

    logic [16:0] r_count;
    logic [32:0] r_num;
    logic [15:0] r_rem;
    logic [5:0]  r_cnt;
    logic [32:0] r_ma;
    logic [65:0] r_prod;
    logic [32:0] r_s2, r_h32, r_g;
    logic [65:0] r_ph;
    logic [62:0] r_pg;
    logic [2:0][31:0] r_wpos;
    logic [2:0][35:0] r_wvel, r_wacc;
    logic signed [39:0] r_cx, r_cy;
    logic signed [19:0] r_cz, r_cfixv;
    logic        r_cfix;
    logic        r_ovalid;

    // normalized time and the values derived from it
    logic [16:0] w_s;
    logic [17:0] w_u2;
    logic        w_uneg;
    logic [16:0] w_au;
    assign w_s    = (i_dur == 16'd0) ? 17'd0 : r_num[16:0];
    assign w_u2   = {w_s, 1'b0};
    assign w_uneg = (w_s < 17'd32768);
    assign w_au   = w_uneg ? 17'(18'd65536 - w_u2) : 17'(w_u2 - 18'd65536);

    // axis difference and magnitude
    logic signed [32:0] w_r0, w_rf, w_d;
    logic               w_neg;
    logic [32:0]        w_ad;
    assign w_r0  = {i_start[i_cmd.axis][31], i_start[i_cmd.axis]};
    assign w_rf  = {i_end[i_cmd.axis][31], i_end[i_cmd.axis]};
    assign w_d   = w_r0 - w_rf;
    assign w_neg = w_d[32];
    assign w_ad  = w_neg ? 33'(-w_d) : 33'(w_d);

    // divider step
    logic [16:0] w_dt;
    logic        w_dge;
    assign w_dt  = {r_rem, r_num[32]};
    assign w_dge = (w_dt >= {1'b0, i_dur});

    // multiplier step
    logic [33:0] w_msum;
    assign w_msum = {1'b0, r_prod[65:33]} + (r_prod[0] ? {1'b0, r_ma} : 34'd0);

    // blend h from s^2 and s^3, and g from s and s^2
    logic [50:0] w_3s2, w_h48, w_h48r;
    logic [32:0] w_g;
    assign w_3s2  = {2'b00, r_s2, 16'd0} + {1'b0, r_s2, 17'd0};
    assign w_h48  = w_3s2 - {1'b0, r_prod[48:0], 1'b0};
    assign w_h48r = w_h48 + 51'h8000;
    assign w_g    = {w_s, 16'd0} - r_s2;

    // axis finish
    logic [65:0]        w_pms;
    logic signed [33:0] w_pm, w_p0, w_pos;
    logic [64:0]        w_3pg;
    logic [35:0]        w_vm, w_am, w_vel, w_acc;
    logic [52:0]        w_6pu;
    assign w_pms = r_ph + 66'h8000_0000;
    assign w_pm  = signed'(w_pms[65:32]);
    assign w_p0  = {w_r0[32], w_r0};
    assign w_pos = w_neg ? (w_p0 + w_pm) : (w_p0 - w_pm);
    assign w_3pg = {2'b00, r_pg} + {1'b0, r_pg, 1'b0} + 65'h4000_0000;
    assign w_vm  = {2'b00, w_3pg[64:31]};
    assign w_6pu = {2'b00, r_prod[49:0], 1'b0} + {1'b0, r_prod[49:0], 2'b00} + 53'h8000;
    assign w_am  = w_6pu[51:16];
    assign w_vel = w_neg ? w_vm : 36'(-w_vm);
    assign w_acc = (w_neg ^ w_uneg) ? 36'(-w_am) : w_am;

    // CORDIC step
    logic signed [35:0] w_vx, w_vy;
    logic signed [39:0] w_xs, w_ys;
    logic signed [19:0] w_at, w_zc;
    logic [18:0]        w_head;
    assign w_vx = signed'(r_wvel[0]);
    assign w_vy = signed'(r_wvel[1]);
    assign w_xs = r_cx >>> r_cnt[3:0];
    assign w_ys = r_cy >>> r_cnt[3:0];
    assign w_at = signed'({3'b000, atan_q16(r_cnt[3:0])});
    assign w_zc = (r_cz > PI_Q16) ? PI_Q16 : ((r_cz < -PI_Q16) ? -PI_Q16 : r_cz);
    assign w_head = r_cfix ? r_cfixv[18:0] : w_zc[18:0];

    // status
    assign o_stat.over     = (r_count > {1'b0, i_dur});
    assign o_stat.last     = (r_cnt == ((i_cmd.op == OP_COR_STEP) ? LAST_CRD : LAST_BIT));
    assign o_stat.out_free = !r_ovalid || !i_stall;

    // control registers: tick count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 17'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_OUT) begin
                r_count <= r_count + 17'd1;
            end else if (i_cmd.op == OP_LOAD && i_restart) begin
                r_count <= 17'd0;
            end
            r_ovalid <= (i_cmd.op == OP_OUT) || (r_ovalid && i_stall);
        end
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_DIV_INIT: begin
                r_num <= {r_count, 16'd0};
                r_rem <= 16'd0;
                r_cnt <= 6'd0;
            end
            OP_DIV_STEP: begin
                r_num <= {r_num[31:0], w_dge};
                r_rem <= w_dge ? 16'(w_dt - {1'b0, i_dur}) : w_dt[15:0];
                r_cnt <= r_cnt + 6'd1;
            end
            OP_MUL_INIT: begin
                r_cnt <= 6'd0;
                case (i_cmd.sel)
                    MS_SS: begin
                        r_ma   <= {16'd0, w_s};
                        r_prod <= {49'd0, w_s};
                    end
                    MS_S3: begin
                        r_ma   <= r_s2;
                        r_prod <= {49'd0, w_s};
                    end
                    MS_PH: begin
                        r_ma   <= w_ad;
                        r_prod <= {33'd0, r_h32};
                    end
                    MS_PG: begin
                        r_ma   <= w_ad;
                        r_prod <= {33'd0, r_g};
                    end
                    default: begin
                        r_ma   <= w_ad;
                        r_prod <= {49'd0, w_au};
                    end
                endcase
            end
            OP_MUL_STEP: begin
                r_prod <= {w_msum, r_prod[32:1]};
                r_cnt  <= r_cnt + 6'd1;
            end
            OP_MUL_STORE: begin
                case (i_cmd.sel)
                    MS_SS: r_s2 <= r_prod[32:0];
                    MS_S3: begin
                        r_h32 <= w_h48r[48:16];
                        r_g   <= w_g;
                    end
                    MS_PH: r_ph <= r_prod;
                    MS_PG: r_pg <= r_prod[62:0];
                    default: begin
                        r_wpos[i_cmd.axis] <= w_pos[31:0];
                        r_wvel[i_cmd.axis] <= w_vel;
                        r_wacc[i_cmd.axis] <= w_acc;
                    end
                endcase
            end
            OP_COR_INIT: begin
                r_cnt <= 6'd0;
                r_cfix  <= (w_vy == 36'sd0);
                r_cfixv <= (w_vx < 36'sd0) ? PI_Q16 : 20'sd0;
                if (w_vx < 36'sd0) begin
                    r_cx <= -40'(w_vx);
                    r_cy <= -40'(w_vy);
                    r_cz <= (w_vy >= 36'sd0) ? PI_Q16 : -PI_Q16;
                end else begin
                    r_cx <= 40'(w_vx);
                    r_cy <= 40'(w_vy);
                    r_cz <= 20'sd0;
                end
            end
            OP_COR_STEP: begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cy > 40'sd0) begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_cz <= r_cz + w_at;
                end else begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_cz <= r_cz - w_at;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            o_pos        <= r_wpos;
            o_vel        <= r_wvel;
            o_acc        <= r_wacc;
            o_heading    <= w_head;
            o_tick_index <= r_count[15:0];
        end
    end

    assign o_valid = r_ovalid;

endmodule
`default_nettype wire
